/* sv/assert_macros.svh */
// assert_macros.svh: assertion helpers for the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion, muted while reset is held
`define NBG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("nbg assertion failed");
// clocked assertion that also holds while reset is held
`define NBG_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("nbg reset assertion failed");
`endif

/* sv/nbg_pkg.sv */
// nbg_pkg: widths, reset values, codes and types of the n-body acceleration block
// no dependencies
package nbg_pkg;
  localparam int IDX_W             = 10;
  localparam int DATA_W            = 32;
  localparam int CUT_W             = 31;
  localparam int CNT_W             = 11;
  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int QUEUE_DEPTH       = 4;
  localparam int DIV_W             = 64;
  localparam int ROOT_W            = 32;
  localparam int SQ_W              = 2 * ROOT_W;
  localparam int MAG_W             = 33;
  localparam int MUL_W             = 34;
  localparam int PROD_W            = 2 * MUL_W;
  localparam int G_W               = 34;
  localparam int U_W               = 31;
  localparam int ACC_W             = 64;
  localparam int FRAC_SHIFT        = 30;
  localparam int APB_ADDR_W        = 4;
  localparam int APB_DATA_W        = 32;
  localparam int REG_SEL_W         = 2;

  localparam logic [DATA_W-1:0] GRAV_RESET   = 32'd19325463;
  localparam logic [CUT_W-1:0]  CUTOFF_RESET = 31'd3277;
  localparam logic [CNT_W-1:0]  COUNT_RESET  = 11'd1024;

  // register indexes on the configuration port
  localparam logic [REG_SEL_W-1:0] REG_GRAV   = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_CUTOFF = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_COUNT  = 2'd2;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef struct packed {
    req_e                      req;
    logic [IDX_W-1:0]          idx;
    logic signed [DATA_W-1:0]  px;
    logic signed [DATA_W-1:0]  py;
    logic signed [DATA_W-1:0]  pz;
    logic [DATA_W-1:0]         mass;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          index;
    logic signed [DATA_W-1:0]  ax;
    logic signed [DATA_W-1:0]  ay;
    logic signed [DATA_W-1:0]  az;
    logic                      sat;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] grav;
    logic [CUT_W-1:0]  cutoff;
    logic [CNT_W-1:0]  count;
  } cfg_t;
endpackage

/* sv/nbody_gravity_acceleration_top.sv */
// nbody_gravity_acceleration_top: configuration registers, front queue, pair engine, result slot
// depends on nbg_pkg, nbg_front, nbg_back
//
//  channel   handshake                 payload
//  input     push / full               req_type, particle_index, pos_x/y/z, mass
//  result    empty / pop               result_index, acc_x/y/z, saturated
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// a load passes the staging register and the queue, then the idle engine writes it into the table
// a query walks every counted pair through the shared 64-step divider (four divisions
// per pair) and the 32-step root; a pair dropped by the cutoff skips the divisions, and
// the queried entry itself is passed over
// reset clears control only; the particle table holds nothing until loaded
// the queue holds four items and staging one more; a finished result waits in its own slot
module nbody_gravity_acceleration_top
  import nbg_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic                    req_type_i,
  input  logic [IDX_W-1:0]        particle_index_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] pos_z_i,
  input  logic [DATA_W-1:0]       mass_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [IDX_W-1:0]        result_index_o,
  output logic signed [DATA_W-1:0] acc_x_o,
  output logic signed [DATA_W-1:0] acc_y_o,
  output logic signed [DATA_W-1:0] acc_z_o,
  output logic                    saturated_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready
);
  localparam int ADDR_W = $clog2(MAX_PARTICLES);

  cfg_t              cfg_q;
  item_t             in_item, q_item;
  logic              q_valid, q_pop;
  logic [ADDR_W-1:0] q_addr;
  logic              res_valid, res_take, slot_v_q;
  result_t           res, slot_q;
  logic [REG_SEL_W-1:0] reg_sel;

  assign in_item.req  = req_e'(req_type_i);
  assign in_item.idx  = particle_index_i;
  assign in_item.px   = pos_x_i;
  assign in_item.py   = pos_y_i;
  assign in_item.pz   = pos_z_i;
  assign in_item.mass = mass_i;

  nbg_front #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .ADDR_W        (ADDR_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (in_item),
    .full_o    (full),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_addr_o  (q_addr),
    .q_pop_i   (q_pop)
  );

  nbg_back #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .ADDR_W        (ADDR_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_addr_i    (q_addr),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_SEL_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grav   <= GRAV_RESET;
      cfg_q.cutoff <= CUTOFF_RESET;
      cfg_q.count  <= COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_GRAV:   cfg_q.grav   <= pwdata;
        REG_CUTOFF: cfg_q.cutoff <= pwdata[CUT_W-1:0];
        REG_COUNT:  cfg_q.count  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GRAV:   prdata = cfg_q.grav;
      REG_CUTOFF: prdata = APB_DATA_W'(cfg_q.cutoff);
      REG_COUNT:  prdata = APB_DATA_W'(cfg_q.count);
      default:    prdata = '0;
    endcase
  end

  // result slot
  assign res_take = res_valid && (!slot_v_q || pop);
  assign empty    = !slot_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_v_q <= 1'b0;
    end else if (res_take) begin
      slot_v_q <= 1'b1;
    end else if (pop) begin
      slot_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      slot_q <= res;
    end
  end

  assign result_index_o = slot_q.index;
  assign acc_x_o        = slot_q.ax;
  assign acc_y_o        = slot_q.ay;
  assign acc_z_o        = slot_q.az;
  assign saturated_o    = slot_q.sat;
endmodule

/* sv/nbg_front.sv */
// nbg_front: takes items, folds the index into the table range, queues them
// depends on nbg_pkg
module nbg_front
  import nbg_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int ADDR_W        = $clog2(MAX_PARTICLES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  item_t             item_i,
  output logic              full_o,
  output logic              q_valid_o,
  output item_t             q_item_o,
  output logic [ADDR_W-1:0] q_addr_o,
  input  logic              q_pop_i
);
  localparam int RW    = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [RW-1:0]    MAX_R  = RW'(MAX_PARTICLES);
  localparam logic [PTR_W:0]   FILL_F = (PTR_W + 1)'(QUEUE_DEPTH);

  logic              stg_v_q;
  item_t             stg_item_q;
  logic [RW-1:0]     red_q;
  logic              red_ok, room, move, accept;
  item_t             fifo_item_q [QUEUE_DEPTH];
  logic [ADDR_W-1:0] fifo_addr_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [PTR_W:0]    fill_q;

  assign red_ok    = red_q < MAX_R;
  assign room      = fill_q != FILL_F;
  assign move      = stg_v_q && red_ok && room;
  assign full_o    = stg_v_q && !move;
  assign accept    = push_i && !full_o;
  assign q_valid_o = fill_q != '0;
  assign q_item_o  = fifo_item_q[rd_q];
  assign q_addr_o  = fifo_addr_q[rd_q];

  // staging and queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      wr_q    <= '0;
      rd_q    <= '0;
      fill_q  <= '0;
    end else begin
      if (accept) begin
        stg_v_q <= 1'b1;
      end else if (move) begin
        stg_v_q <= 1'b0;
      end
      if (move) begin
        wr_q <= wr_q + 1'b1;
      end
      if (q_pop_i && q_valid_o) begin
        rd_q <= rd_q + 1'b1;
      end
      fill_q <= fill_q + (PTR_W + 1)'(move) - (PTR_W + 1)'(q_pop_i && q_valid_o);
    end
  end

  // staging payload, index folded by repeated subtraction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_item_q <= item_i;
      red_q      <= RW'(item_i.idx);
    end else if (stg_v_q && !red_ok) begin
      red_q <= red_q - MAX_R;
    end
    if (move) begin
      fifo_item_q[wr_q] <= stg_item_q;
      fifo_addr_q[wr_q] <= red_q[ADDR_W-1:0];
    end
  end
endmodule

/* sv/nbg_div.sv */
// nbg_div: restoring divider, one quotient bit per cycle
// depends on nbg_pkg
module nbg_div
  import nbg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);
  localparam int STEP_W = $clog2(DIV_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DIV_W:0]    rem_q, rem_sh, rem_nx;
  logic [DIV_W-1:0]  num_q, den_q;
  logic              ge;

  assign rem_sh = {rem_q[DIV_W-1:0], num_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  assign done_o = done_q;
  assign quo_o  = num_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      num_q <= {num_q[DIV_W-2:0], ge};
    end
  end
endmodule

/* sv/nbg_sqrt.sv */
// nbg_sqrt: integer square root, one result bit per cycle
// depends on nbg_pkg
module nbg_sqrt
  import nbg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   val_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);
  localparam int STEP_W = $clog2(ROOT_W);
  localparam int SH_W   = $clog2(SQ_W) + 1;
  localparam logic [SH_W-1:0] TOP_SH = SH_W'(SQ_W - 2);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [SQ_W-1:0]   v_q, r_q, bit_w, trial;
  logic              ge;

  assign bit_w  = SQ_W'(1) << (TOP_SH - SH_W'({cnt_q, 1'b0}));
  assign trial  = r_q + bit_w;
  assign ge     = v_q >= trial;
  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // digit-by-digit root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= val_i;
      r_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_w;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end
endmodule

/* sv/nbg_back.sv */
// nbg_back: particle table and pair sequencer with shared multiplier, divider and root
// depends on nbg_pkg, nbg_div, nbg_sqrt
module nbg_back
  import nbg_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int ADDR_W        = $clog2(MAX_PARTICLES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  input  logic [ADDR_W-1:0] q_addr_i,
  output logic              q_pop_o,
  input  cfg_t              cfg_i,
  output logic              res_valid_o,
  output result_t           res_o,
  input  logic              res_take_i
);
  localparam int CW    = (CNT_W > ADDR_W + 1) ? CNT_W : ADDR_W + 1;
  localparam int ENT_W = 4 * DATA_W;
  localparam logic [CW-1:0]    MAX_C = CW'(MAX_PARTICLES);
  localparam logic [DIV_W-1:0] G_CAP = DIV_W'(1) << (G_W - 1);
  localparam logic [DIV_W-1:0] U_CAP = DIV_W'(1) << FRAC_SHIFT;
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(64'h7fff_ffff);
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI - ACC_W'(1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LATI   = 4'd1;
  localparam logic [3:0] ST_NEXT   = 4'd2;
  localparam logic [3:0] ST_DIFF   = 4'd3;
  localparam logic [3:0] ST_SQ0    = 4'd4;
  localparam logic [3:0] ST_SQ1    = 4'd5;
  localparam logic [3:0] ST_SQ2    = 4'd6;
  localparam logic [3:0] ST_SQ3    = 4'd7;
  localparam logic [3:0] ST_ROOT   = 4'd8;
  localparam logic [3:0] ST_MULG   = 4'd9;
  localparam logic [3:0] ST_GSTART = 4'd10;
  localparam logic [3:0] ST_GWAIT  = 4'd11;
  localparam logic [3:0] ST_USTART = 4'd12;
  localparam logic [3:0] ST_UWAIT  = 4'd13;
  localparam logic [3:0] ST_UACC   = 4'd14;
  localparam logic [3:0] ST_DONE   = 4'd15;

  logic [3:0]               st_q, st_d;
  logic [ENT_W-1:0]         mem_q [MAX_PARTICLES];
  logic [ENT_W-1:0]         rdata_q;
  logic [ADDR_W-1:0]        rd_addr, addr_q;
  item_t                    item_q;
  logic [CW-1:0]            cnt_q, j_q, cnt_sel;
  logic signed [DATA_W-1:0] ri_q  [3];
  logic [MAG_W-1:0]         mag_q [3];
  logic                     neg_q [3];
  logic signed [ACC_W-1:0]  acc_q [3];
  logic signed [ACC_W-1:0]  acc_clip [3];
  logic                     clip_hit [3];
  logic [DATA_W-1:0]        mj_q;
  logic [SQ_W-1:0]          s_q;
  logic [MAG_W-1:0]         d_q, d_new;
  logic [DIV_W-1:0]         dd_q;
  logic [G_W-1:0]           g_q, g_new;
  logic [U_W-1:0]           u_new;
  logic [1:0]               k_q;
  logic                     sat_q;
  logic [PROD_W-1:0]        prod_q;
  logic [MUL_W-1:0]         mul_a, mul_b;
  logic                     j_end, j_self, d_skip;
  logic signed [ACC_W-1:0]  term;
  logic                     div_start, div_done, sq_start, sq_done;
  logic [DIV_W-1:0]         div_num, div_den, div_quo;
  logic [SQ_W-1:0]          sq_val;
  logic [ROOT_W-1:0]        root;

  nbg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  nbg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_val),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // pair arithmetic helpers
  assign cnt_sel = (CW'(cfg_i.count) < MAX_C) ? CW'(cfg_i.count) : MAX_C;
  assign rd_addr = (st_q == ST_IDLE) ? q_addr_i : j_q[ADDR_W-1:0];
  assign j_end   = j_q >= cnt_q;
  assign j_self  = j_q[ADDR_W-1:0] == addr_q;
  assign d_new   = {root, 1'b0};
  assign d_skip  = (d_new <= MAG_W'(cfg_i.cutoff)) || d_new[MAG_W-1];
  assign g_new   = (div_quo > G_CAP) ? G_W'(G_CAP) : div_quo[G_W-1:0];
  assign u_new   = (div_quo > U_CAP) ? U_W'(U_CAP) : div_quo[U_W-1:0];
  assign term    = $signed({{FRAC_SHIFT{1'b0}}, prod_q[ACC_W-1:FRAC_SHIFT]});
  assign sq_val  = s_q + prod_q[2*MAG_W-1:2];

  // final clipping to 32 bits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clip_hit[k] = 1'b0;
      acc_clip[k] = acc_q[k];
      if (acc_q[k] > ACC_HI) begin
        acc_clip[k] = ACC_HI;
        clip_hit[k] = 1'b1;
      end else if (acc_q[k] < ACC_LO) begin
        acc_clip[k] = ACC_LO;
        clip_hit[k] = 1'b1;
      end
    end
  end

  assign res_valid_o = st_q == ST_DONE;
  assign res_o.index = item_q.idx;
  assign res_o.ax    = acc_clip[0][DATA_W-1:0];
  assign res_o.ay    = acc_clip[1][DATA_W-1:0];
  assign res_o.az    = acc_clip[2][DATA_W-1:0];
  assign res_o.sat   = sat_q || clip_hit[0] || clip_hit[1] || clip_hit[2];

  // sequencer: next state and unit controls
  always_comb begin
    st_d      = st_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.req == REQ_QUERY) begin
            st_d = ST_LATI;
          end
        end
      end
      ST_LATI: st_d = ST_NEXT;
      ST_NEXT: begin
        if (j_end) begin
          st_d = ST_DONE;
        end else if (!j_self) begin
          st_d = ST_DIFF;
        end
      end
      ST_DIFF: st_d = ST_SQ0;
      ST_SQ0: begin
        mul_a = MUL_W'(mag_q[0]);
        mul_b = MUL_W'(mag_q[0]);
        st_d  = ST_SQ1;
      end
      ST_SQ1: begin
        mul_a = MUL_W'(mag_q[1]);
        mul_b = MUL_W'(mag_q[1]);
        st_d  = ST_SQ2;
      end
      ST_SQ2: begin
        mul_a = MUL_W'(mag_q[2]);
        mul_b = MUL_W'(mag_q[2]);
        st_d  = ST_SQ3;
      end
      ST_SQ3: begin
        sq_start = 1'b1;
        st_d     = ST_ROOT;
      end
      ST_ROOT: begin
        mul_a = MUL_W'(d_new);
        mul_b = MUL_W'(d_new);
        if (sq_done) begin
          st_d = d_skip ? ST_NEXT : ST_MULG;
        end
      end
      ST_MULG: begin
        mul_a = MUL_W'(cfg_i.grav);
        mul_b = MUL_W'(mj_q);
        st_d  = ST_GSTART;
      end
      ST_GSTART: begin
        div_start = 1'b1;
        div_num   = prod_q[DIV_W-1:0];
        div_den   = dd_q;
        st_d      = ST_GWAIT;
      end
      ST_GWAIT: begin
        if (div_done) begin
          st_d = ST_USTART;
        end
      end
      ST_USTART: begin
        div_start = 1'b1;
        div_num   = DIV_W'(mag_q[k_q]) << FRAC_SHIFT;
        div_den   = DIV_W'(d_q);
        st_d      = ST_UWAIT;
      end
      ST_UWAIT: begin
        mul_a = g_q;
        mul_b = MUL_W'(u_new);
        if (div_done) begin
          st_d = ST_UACC;
        end
      end
      ST_UACC: st_d = (k_q == 2'd2) ? ST_NEXT : ST_USTART;
      ST_DONE: begin
        if (res_take_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // particle table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && q_valid_i && q_item_i.req == REQ_LOAD) begin
      mem_q[q_addr_i] <= {q_item_i.px, q_item_i.py, q_item_i.pz, q_item_i.mass};
    end
    rdata_q <= mem_q[rd_addr];
  end

  // shared multiplier, registered
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // working registers of the pair walk
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i && q_item_i.req == REQ_QUERY) begin
          item_q <= q_item_i;
          addr_q <= q_addr_i;
          cnt_q  <= cnt_sel;
          j_q    <= '0;
          sat_q  <= 1'b0;
          for (int k = 0; k < 3; k++) begin
            acc_q[k] <= '0;
          end
        end
      end
      ST_LATI: begin
        for (int k = 0; k < 3; k++) begin
          ri_q[k] <= rdata_q[ENT_W-1-k*DATA_W -: DATA_W];
        end
      end
      ST_NEXT: begin
        if (!j_end && j_self) begin
          j_q <= j_q + 1'b1;
        end
      end
      ST_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          logic [MAG_W-1:0] dv;
          dv = {rdata_q[ENT_W-1-k*DATA_W], rdata_q[ENT_W-1-k*DATA_W -: DATA_W]}
             - {ri_q[k][DATA_W-1], ri_q[k]};
          neg_q[k] <= dv[MAG_W-1];
          mag_q[k] <= dv[MAG_W-1] ? -dv : dv;
        end
        mj_q <= rdata_q[DATA_W-1:0];
      end
      ST_SQ0: s_q <= '0;
      ST_SQ1, ST_SQ2: s_q <= sq_val;
      ST_ROOT: begin
        if (sq_done) begin
          if (d_skip) begin
            j_q <= j_q + 1'b1;
          end else begin
            d_q <= d_new;
          end
        end
      end
      ST_MULG: dd_q <= prod_q[DIV_W-1:0];
      ST_GWAIT: begin
        if (div_done) begin
          g_q <= g_new;
          k_q <= '0;
          if (div_quo > G_CAP) begin
            sat_q <= 1'b1;
          end
        end
      end
      ST_UACC: begin
        if (neg_q[k_q]) begin
          acc_q[k_q] <= acc_q[k_q] - term;
        end else begin
          acc_q[k_q] <= acc_q[k_q] + term;
        end
        k_q <= k_q + 1'b1;
        if (k_q == 2'd2) begin
          j_q <= j_q + 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

/* sv/nbg_checker.sv */
// nbg_checker: port-level checks of the n-body acceleration top, bound to it below
// depends on nbg_pkg and assert_macros.svh
`include "assert_macros.svh"
module nbg_checker
  import nbg_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [IDX_W-1:0]      result_index_o,
  input logic [DATA_W-1:0]     acc_x_o,
  input logic [DATA_W-1:0]     acc_y_o,
  input logic [DATA_W-1:0]     acc_z_o,
  input logic                  saturated_o,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata
);
  // nothing waits and nothing is refused while reset is held
  `NBG_ASSERT_RST(a_reset_quiet, clk_i, !rst_ni |-> (empty && !full))
  // a waiting result holds until taken
  `NBG_ASSERT(a_result_holds, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(result_index_o) && $stable(acc_x_o) && $stable(acc_y_o) && $stable(acc_z_o) && $stable(saturated_o)))
  // a written gravity constant reads back
  `NBG_ASSERT(a_grav_readback, clk_i, rst_ni, (psel && penable && pwrite && paddr[3:2] == REG_GRAV) |=> (paddr[3:2] != REG_GRAV || prdata == $past(pwdata)))
  // a written particle count reads back
  `NBG_ASSERT(a_count_readback, clk_i, rst_ni, (psel && penable && pwrite && paddr[3:2] == REG_COUNT) |=> (paddr[3:2] != REG_COUNT || prdata[10:0] == $past(pwdata[10:0])))
endmodule

bind nbody_gravity_acceleration_top nbg_checker u_nbg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .result_index_o (result_index_o),
  .acc_x_o        (acc_x_o),
  .acc_y_o        (acc_y_o),
  .acc_z_o        (acc_z_o),
  .saturated_o    (saturated_o),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

/* tb/testbench.sv */
// testbench for nbody_gravity_acceleration_top: drives load and query items, predicts results
// depends on nbg_pkg and the nbody_gravity_acceleration_top rtl
`timescale 1ns / 100ps

module testbench;
  import nbg_pkg::*;

  localparam int TAB_DEPTH  = 1024;
  localparam int STALL_LIMIT = 50000;
  localparam int SETTLE_CYC  = 40;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     push = 1'b0;
  logic                     full;
  logic                     req_type_i = 1'b0;
  logic [IDX_W-1:0]         particle_index_i = '0;
  logic signed [DATA_W-1:0] pos_x_i = '0;
  logic signed [DATA_W-1:0] pos_y_i = '0;
  logic signed [DATA_W-1:0] pos_z_i = '0;
  logic [DATA_W-1:0]        mass_i = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [IDX_W-1:0]         result_index_o;
  logic signed [DATA_W-1:0] acc_x_o;
  logic signed [DATA_W-1:0] acc_y_o;
  logic signed [DATA_W-1:0] acc_z_o;
  logic                     saturated_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]    paddr = '0;
  logic [APB_DATA_W-1:0]    pwdata = '0;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  nbody_gravity_acceleration_top dut (
    .clk_i, .rst_ni, .push, .full, .req_type_i, .particle_index_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .mass_i, .empty, .pop,
    .result_index_o, .acc_x_o, .acc_y_o, .acc_z_o, .saturated_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // clock
  always #1 clk_i = ~clk_i;

  // predictor state: particle table and register copies
  logic [DATA_W-1:0] tab_x [TAB_DEPTH];
  logic [DATA_W-1:0] tab_y [TAB_DEPTH];
  logic [DATA_W-1:0] tab_z [TAB_DEPTH];
  logic [DATA_W-1:0] tab_m [TAB_DEPTH];
  logic [DATA_W-1:0] grav_q = GRAV_RESET;
  logic [CUT_W-1:0]  cutoff_q = CUTOFF_RESET;
  logic [CNT_W-1:0]  count_q = COUNT_RESET;

  item_t   pending_items[$];
  result_t expected_accels[$];
  bit      loaded [TAB_DEPTH];
  int      loaded_list[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      push_gap = 0;
  int      pop_gap = 0;

  // floor square root, bit by bit
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // summed pull on one particle from every counted entry
  function automatic result_t accel_of(logic [IDX_W-1:0] idx);
    result_t     res;
    longint      acc [3];
    longint      ri [3];
    longint      dv [3];
    logic [63:0] mag [3];
    logic [63:0] s, d, g, u, term;
    int          cnt;
    bit          sat;
    sat = 1'b0;
    cnt = (count_q > TAB_DEPTH) ? TAB_DEPTH : int'(count_q);
    for (int k = 0; k < 3; k++) acc[k] = 0;
    ri[0] = longint'($signed(tab_x[idx]));
    ri[1] = longint'($signed(tab_y[idx]));
    ri[2] = longint'($signed(tab_z[idx]));
    for (int j = 0; j < cnt; j++) begin
      if (j == int'(idx)) continue;
      dv[0] = longint'($signed(tab_x[j])) - ri[0];
      dv[1] = longint'($signed(tab_y[j])) - ri[1];
      dv[2] = longint'($signed(tab_z[j])) - ri[2];
      s = '0;
      for (int k = 0; k < 3; k++) begin
        mag[k] = (dv[k] < 0) ? 64'(-dv[k]) : 64'(dv[k]);
        s = s + ((mag[k] * mag[k]) >> 2);
      end
      d = floor_root(s) << 1;
      if (d <= 64'(cutoff_q)) continue;
      if (d >= (64'h1 << 32)) begin
        g = '0;
      end else begin
        g = (64'(grav_q) * 64'(tab_m[j])) / (d * d);
        if (g > (64'h1 << 33)) begin
          g = 64'h1 << 33;
          sat = 1'b1;
        end
      end
      for (int k = 0; k < 3; k++) begin
        u = (mag[k] << FRAC_SHIFT) / d;
        if (u > (64'h1 << FRAC_SHIFT)) u = 64'h1 << FRAC_SHIFT;
        term = (g * u) >> FRAC_SHIFT;
        if (dv[k] < 0) acc[k] = acc[k] - longint'(term);
        else acc[k] = acc[k] + longint'(term);
      end
    end
    // clip each component to 32 bits
    for (int k = 0; k < 3; k++) begin
      if (acc[k] > 64'sd2147483647) begin
        acc[k] = 64'sd2147483647;
        sat = 1'b1;
      end else if (acc[k] < -64'sd2147483648) begin
        acc[k] = -64'sd2147483648;
        sat = 1'b1;
      end
    end
    res.index = idx;
    res.ax = acc[0][31:0];
    res.ay = acc[1][31:0];
    res.az = acc[2][31:0];
    res.sat = sat;
    return res;
  endfunction

  // random gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // driver: accepts an item, feeds the predictor, presents the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        if (req_type_i == REQ_LOAD) begin
          tab_x[particle_index_i] = pos_x_i;
          tab_y[particle_index_i] = pos_y_i;
          tab_z[particle_index_i] = pos_z_i;
          tab_m[particle_index_i] = mass_i;
        end else begin
          expected_accels.push_back(accel_of(particle_index_i));
        end
        push_gap = pick_gap();
      end
      if (!push || !full) begin
        if (push_gap > 0 || pending_items.size() == 0) begin
          if (push_gap > 0) push_gap--;
          push <= 1'b0;
        end else begin
          item_t it;
          it = pending_items.pop_front();
          push <= 1'b1;
          req_type_i <= it.req;
          particle_index_i <= it.idx;
          pos_x_i <= it.px;
          pos_y_i <= it.py;
          pos_z_i <= it.pz;
          mass_i <= it.mass;
        end
      end
    end
  end

  // monitor: compares each popped item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_accels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result index %0d", result_index_o);
        end else begin
          result_t e;
          e = expected_accels.pop_front();
          if (result_index_o !== e.index || acc_x_o !== e.ax || acc_y_o !== e.ay ||
              acc_z_o !== e.az || saturated_o !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp idx %0d acc %h %h %h sat %b, got idx %0d acc %h %h %h sat %b",
                       e.index, e.ax, e.ay, e.az, e.sat, result_index_o,
                       acc_x_o, acc_y_o, acc_z_o, saturated_o);
          end
        end
        pop_gap = pick_gap();
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] rand_pos();
    if ($urandom_range(0, 9) < 2) return $urandom;
    return DATA_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
  endfunction

  task automatic add_load(int idx, logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                          logic [DATA_W-1:0] z, logic [DATA_W-1:0] m);
    item_t it;
    it.req = REQ_LOAD;
    it.idx = IDX_W'(idx);
    it.px = x;
    it.py = y;
    it.pz = z;
    it.mass = m;
    pending_items.push_back(it);
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  task automatic add_rand_load(int idx);
    add_load(idx, rand_pos(), rand_pos(), rand_pos(), $urandom);
  endtask

  task automatic add_query(int idx);
    item_t it;
    it = '0;
    it.req = REQ_QUERY;
    it.idx = IDX_W'(idx);
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    it.mass = $urandom;
    pending_items.push_back(it);
  endtask

  // wait until every item is sent and every result is back, then let loads settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || push || expected_accels.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // register write: setup cycle then access cycle
  task automatic reg_write(logic [REG_SEL_W-1:0] sel, logic [APB_DATA_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * sel);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_GRAV:   grav_q = val;
      REG_CUTOFF: cutoff_q = val[CUT_W-1:0];
      default:    count_q = val[CNT_W-1:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // stimulus and end of run
  initial begin
    int n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, close pair, far corners, zero mass
    reg_write(REG_GRAV, 32'hFFFF_FFFF);
    reg_write(REG_CUTOFF, '0);
    reg_write(REG_COUNT, 32'd4);
    add_load(0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    add_load(1, 32'd2, 32'd0, 32'd0, 32'hFFFF_FFFF);
    add_load(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0);
    add_load(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_load(1023, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0100_0000);
    for (int i = 0; i < 4; i++) add_query(i);
    // queried entry above the active count
    add_query(1023);
    wait_drained();
    reg_write(REG_COUNT, 32'd1);
    add_query(0);
    add_query(3);
    wait_drained();
    // zero count gives an all-zero sum
    reg_write(REG_COUNT, 32'd0);
    add_query(1);
    wait_drained();
    reg_write(REG_GRAV, 32'd0);
    reg_write(REG_CUTOFF, 32'h7FFF_FFFF);
    reg_write(REG_COUNT, 32'd4);
    add_query(2);
    add_query(3);
    wait_drained();
    reg_write(REG_COUNT, 32'd1024);
    for (int i = 0; i < 16; i++) add_rand_load(i);
    wait_drained();

    // random phases with fresh settings each
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(REG_GRAV, ($urandom_range(0, 2) == 0) ? GRAV_RESET : $urandom);
      reg_write(REG_CUTOFF, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                                        : $urandom_range(0, 1 << 17));
      reg_write(REG_COUNT, ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16)
                                                       : $urandom_range(1, 8));
      for (n = 0; n < 112; n++) begin
        if (ph == 2 && n == 56) wait_drained();
        if ($urandom_range(0, 99) < 60) begin
          if ($urandom_range(0, 9) == 0) add_rand_load($urandom_range(0, TAB_DEPTH - 1));
          else add_rand_load($urandom_range(0, 15));
        end else if ($urandom_range(0, 3) == 0) begin
          add_query(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        end else begin
          add_query($urandom_range(0, 15));
        end
      end
      wait_drained();
    end

    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatches == 0 && expected_accels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
